// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the calibration RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition implies a consequence in the same cycle outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/pldc_pkg.sv -----
// Shared constants and types of the piecewise-linear DAC calibration block.
package pldc_pkg;

	localparam int VOLT_BITS = 15;
	localparam logic [VOLT_BITS-1:0] VOLT_MAX = 15'd20480;

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_CONVERT = 1'b1
	} cmd_t;

	typedef struct packed {
		logic done;
		logic rem_nz;
	} div_status_t;

endpackage

// ----- rtl/core/pldc_table.sv -----
// Calibration point memories: measured voltages and DAC codes, one write and one read port.
module pldc_table #(
	parameter int DEPTH = 21,
	parameter int AW = 5,
	parameter int VB = 15,
	parameter int CW = 12
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [VB-1:0] wr_volts,
	input  logic [CW-1:0] wr_code,
	input  logic [AW-1:0] rd_addr,
	output logic [VB-1:0] rd_volts,
	output logic [CW-1:0] rd_code
);

	logic [VB-1:0] volts_mem [DEPTH];
	logic [CW-1:0] code_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			volts_mem[wr_addr] <= wr_volts;
			code_mem[wr_addr] <= wr_code;
		end
		rd_volts <= volts_mem[rd_addr];
		rd_code <= code_mem[rd_addr];
	end

endmodule

// ----- rtl/core/pldc_div.sv -----
// Unsigned restoring divider that retires two quotient bits per cycle.
`include "assert_macros.svh"

module pldc_div #(
	parameter int DIVIDEND_BITS = 29,
	parameter int DIVISOR_BITS = 16,
	localparam int QW = 2 * ((DIVIDEND_BITS + 1) / 2)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DIVIDEND_BITS-1:0]  dividend,
	input  logic [DIVISOR_BITS-1:0]   divisor,
	output logic [QW-1:0]             quotient,
	output pldc_pkg::div_status_t     status
);

	localparam int STEPS = QW / 2;
	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic                    run_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [QW-1:0]           dq_q;
	logic [DIVISOR_BITS-1:0] rem_q;
	logic [DIVISOR_BITS-1:0] d_q;
	logic [QW-1:0]           dq_n;
	logic [DIVISOR_BITS-1:0] rem_n;

	always_comb begin
		logic [DIVISOR_BITS:0] trial;
		dq_n = dq_q;
		rem_n = rem_q;
		trial = '0;
		for (int k = 0; k < 2; k++) begin
			trial = {rem_n, dq_n[QW-1]};
			dq_n = {dq_n[QW-2:0], 1'b0};
			if (trial >= {1'b0, d_q}) begin
				rem_n = DIVISOR_BITS'(trial - {1'b0, d_q});
				dq_n[0] = 1'b1;
			end else begin
				rem_n = trial[DIVISOR_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= QW'(dividend);
			rem_q <= '0;
			d_q <= divisor;
		end else if (run_q) begin
			dq_q <= dq_n;
			rem_q <= rem_n;
		end
	end

	assign quotient = dq_q;
	assign status.done = done_q;
	assign status.rem_nz = |rem_q;

	`ASSERT_IMPLY(a_div_nonzero, clk, arst_n, run_q, d_q != '0, "divider runs on a zero divisor")
	`ASSERT_IMPLY(a_div_done_idle, clk, arst_n, done_q, !run_q, "divider done while still running")

endmodule

// ----- rtl/core/piecewise_linear_dac_calibration.sv -----
// Top level of the piecewise-linear DAC calibration block: sequencer and interpolation datapath.
//
// A load transaction (command 0) writes one calibration point in the cycle it is accepted and
// leaves busy low, so loads can follow every cycle; a load with an out-of-range dac_select or
// point_index writes nothing. A convert transaction (command 1) holds busy while it compares
// table points in turn until the segment is found (1 to POINT_COUNT-2 points), reads the two
// segment ends, interpolates and runs the divider; a flat segment skips the divider. Each
// compared point takes one table read on the single memory read port, and the divider retires
// two quotient bits per cycle. The result appears on dac_code and flat_segment for exactly one
// cycle with done high, in the first cycle that busy is low again; the receiver cannot stall
// it, so it must capture it then. Table entries hold no value until loaded, and a convert must
// only use points that were loaded.
`include "assert_macros.svh"

module piecewise_linear_dac_calibration #(
	parameter int DAC_COUNT = 3,
	parameter int POINT_COUNT = 7,
	parameter int CODE_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           command,
	input  logic [1:0]                     dac_select,
	input  logic [2:0]                     point_index,
	input  logic [pldc_pkg::VOLT_BITS-1:0] volts,
	input  logic [CODE_BITS-1:0]           point_code,
	output logic                           done,
	output logic [CODE_BITS-1:0]           dac_code,
	output logic                           flat_segment
);

	localparam int VB = pldc_pkg::VOLT_BITS;
	localparam int CW = CODE_BITS;
	localparam int DEPTH = DAC_COUNT * POINT_COUNT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW = $clog2(POINT_COUNT);
	localparam int MAG_BITS = CW + VB + 2;
	localparam int NW = MAG_BITS + 2;
	localparam int PW = CW + VB + 2;
	localparam int DVS_BITS = VB + 1;
	localparam int QW = 2 * ((MAG_BITS + 1) / 2);
	localparam int SW = QW + 2;
	localparam logic [IW-1:0] LAST_SEG = IW'(POINT_COUNT - 2);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_SRD  = 11'b00000000010,
		S_SCMP = 11'b00000000100,
		S_RD0  = 11'b00000001000,
		S_RD1  = 11'b00000010000,
		S_CAP  = 11'b00000100000,
		S_MUL  = 11'b00001000000,
		S_PREP = 11'b00010000000,
		S_ABS  = 11'b00100000000,
		S_DIV  = 11'b01000000000,
		S_WAIT = 11'b10000000000
	} state_t;

	state_t                  state_q;
	logic                    done_q;
	logic                    accept;
	logic                    is_conv;
	logic                    load_ok;
	logic [AW-1:0]           wr_addr;
	logic [AW-1:0]           conv_base;
	logic [AW-1:0]           rd_addr;
	logic [IW-1:0]           rd_ptr;
	logic [VB-1:0]           rd_volts;
	logic [CW-1:0]           rd_code;
	logic [VB-1:0]           t_clamp;

	logic [AW-1:0]           base_q;
	logic [VB-1:0]           t_q;
	logic [IW-1:0]           idx_q;
	logic [IW-1:0]           seg_q;
	logic [CW-1:0]           c0_q;
	logic [VB-1:0]           v0_q;
	logic signed [CW:0]      dc_q;
	logic signed [VB:0]      dt_q;
	logic signed [VB:0]      dv_q;
	logic signed [PW-1:0]    prod_q;
	logic                    dv_neg_q;
	logic [VB-1:0]           den_q;
	logic signed [NW-1:0]    n2_q;
	logic [CW-1:0]           code_q;
	logic                    flat_q;

	logic [VB:0]             dv_abs;
	logic signed [NW-1:0]    prod_ext;
	logic signed [NW-1:0]    n_sel;
	logic signed [NW-1:0]    n2_next;
	logic [NW-1:0]           n2_abs;

	logic                    div_start;
	logic [MAG_BITS-1:0]     div_dividend;
	logic [DVS_BITS-1:0]     div_divisor;
	logic [QW-1:0]           div_quot;
	pldc_pkg::div_status_t   div_stat;

	logic [SW-1:0]           q_ext;
	logic [SW-1:0]           sum_u;
	logic [CW-1:0]           fin_code;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign is_conv = (command == pldc_pkg::CMD_CONVERT);
	assign load_ok = accept && !is_conv && (32'(point_index) < POINT_COUNT)
		&& (32'(dac_select) < DAC_COUNT);
	assign wr_addr = AW'(32'(dac_select) * POINT_COUNT + 32'(point_index));
	assign conv_base = AW'(((32'(dac_select) >= DAC_COUNT) ? 32'(DAC_COUNT - 1)
		: 32'(dac_select)) * POINT_COUNT);
	assign t_clamp = (volts > pldc_pkg::VOLT_MAX) ? pldc_pkg::VOLT_MAX : volts;

	always_comb begin
		case (state_q)
			S_SRD: rd_ptr = idx_q;
			S_RD0: rd_ptr = seg_q;
			default: rd_ptr = seg_q + 1'b1;
		endcase
	end

	assign rd_addr = base_q + AW'(rd_ptr);

	pldc_table #(
		.DEPTH(DEPTH),
		.AW(AW),
		.VB(VB),
		.CW(CW)
	) u_table (
		.clk(clk),
		.wr_en(load_ok),
		.wr_addr(wr_addr),
		.wr_volts(volts),
		.wr_code(point_code),
		.rd_addr(rd_addr),
		.rd_volts(rd_volts),
		.rd_code(rd_code)
	);

	assign dv_abs = dv_q[VB] ? (~dv_q + 1'b1) : dv_q;
	assign prod_ext = NW'(prod_q);
	assign n_sel = dv_neg_q ? -prod_ext : prod_ext;
	assign n2_next = (n_sel <<< 1) + $signed(NW'(den_q));
	assign n2_abs = n2_q[NW-1] ? NW'(-n2_q) : NW'(n2_q);

	assign div_start = (state_q == S_ABS);
	assign div_dividend = n2_abs[MAG_BITS-1:0];
	assign div_divisor = {den_q, 1'b0};

	pldc_div #(
		.DIVIDEND_BITS(MAG_BITS),
		.DIVISOR_BITS(DVS_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.quotient(div_quot),
		.status(div_stat)
	);

	// A negative quotient is floored: c0 - q - 1 when a remainder is left, c0 - q otherwise.
	assign q_ext = SW'(div_quot);
	assign sum_u = SW'(c0_q) + (n2_q[NW-1] ? ~q_ext : q_ext)
		+ SW'(n2_q[NW-1] && !div_stat.rem_nz);
	assign fin_code = sum_u[SW-1] ? '0 : ((|sum_u[SW-2:CW]) ? '1 : sum_u[CW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && is_conv) begin
						state_q <= (POINT_COUNT > 2) ? S_SRD : S_RD0;
					end
				end
				S_SRD: state_q <= S_SCMP;
				S_SCMP: begin
					if ((t_q < rd_volts) || (idx_q == LAST_SEG)) begin
						state_q <= S_RD0;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_CAP;
				S_CAP: state_q <= S_MUL;
				S_MUL: state_q <= S_PREP;
				S_PREP: begin
					if (dv_q == '0) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
					end else begin
						state_q <= S_ABS;
					end
				end
				S_ABS: state_q <= S_DIV;
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && is_conv) begin
					t_q <= t_clamp;
					base_q <= conv_base;
					idx_q <= IW'(1);
					seg_q <= LAST_SEG;
				end
			end
			S_SCMP: begin
				if (t_q < rd_volts) begin
					seg_q <= idx_q - 1'b1;
				end
				idx_q <= idx_q + 1'b1;
			end
			S_RD1: begin
				c0_q <= rd_code;
				v0_q <= rd_volts;
			end
			S_CAP: begin
				dc_q <= $signed({1'b0, rd_code}) - $signed({1'b0, c0_q});
				dt_q <= $signed({1'b0, t_q}) - $signed({1'b0, v0_q});
				dv_q <= $signed({1'b0, rd_volts}) - $signed({1'b0, v0_q});
			end
			S_MUL: begin
				prod_q <= dc_q * dt_q;
				dv_neg_q <= dv_q[VB];
				den_q <= dv_abs[VB-1:0];
			end
			S_PREP: begin
				n2_q <= n2_next;
				if (dv_q == '0) begin
					code_q <= c0_q;
					flat_q <= 1'b1;
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					code_q <= fin_code;
					flat_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign dac_code = code_q;
	assign flat_segment = flat_q;

	`ASSERT_IMPLY(a_done_not_busy, clk, arst_n, done, !busy, "result strobe while busy")
	`ASSERT_IMPLY(a_done_after_work, clk, arst_n, done, $past(busy), "result without a convert")
	`ASSERT_CLK(a_conv_goes_busy, clk, arst_n, (start && !busy && command) |=> busy, "convert not started")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the piecewise-linear DAC calibration block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VOLT_BITS = pldc_pkg::VOLT_BITS;
	localparam logic [VOLT_BITS-1:0] VOLT_MAX = pldc_pkg::VOLT_MAX;

	typedef pldc_pkg::cmd_t cmd_t;

	localparam cmd_t CMD_LOAD = pldc_pkg::CMD_LOAD;
	localparam cmd_t CMD_CONVERT = pldc_pkg::CMD_CONVERT;

	localparam int DAC_COUNT = 3;
	localparam int POINT_COUNT = 7;
	localparam int CODE_BITS = 12;
	localparam int TABLE_DEPTH = DAC_COUNT * POINT_COUNT;
	localparam int CODE_FULL = (1 << CODE_BITS) - 1;
	localparam int MAX_SHOWN = 10;
	localparam int RANDOM_ITEMS = 600;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [CODE_BITS-1:0] code;
		logic                 flat;
	} dac_result_t;

	class dac_code_scoreboard;
		logic [VOLT_BITS-1:0] volts_tab [TABLE_DEPTH];
		logic [CODE_BITS-1:0] code_tab [TABLE_DEPTH];
		dac_result_t          awaited [$];
		int                   errors;

		function void report(string what);
			errors++;
			if (errors <= MAX_SHOWN)
				$display("%s", what);
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function dac_result_t interpolate(int unsigned dac, logic [VOLT_BITS-1:0] v);
			int unsigned base;
			int unsigned seg;
			longint      t;
			longint      c0;
			longint      c1;
			longint      v0;
			longint      v1;
			longint      num;
			longint      den;
			longint      q;
			longint      r;
			dac_result_t res;
			if (dac >= DAC_COUNT)
				dac = DAC_COUNT - 1;
			base = dac * POINT_COUNT;
			t = (v > VOLT_MAX) ? longint'(VOLT_MAX) : longint'(v);
			seg = POINT_COUNT - 2;
			for (int i = POINT_COUNT - 3; i >= 0; i--) begin
				if (t < longint'(volts_tab[base + i + 1]))
					seg = i;
			end
			c0 = code_tab[base + seg];
			c1 = code_tab[base + seg + 1];
			v0 = volts_tab[base + seg];
			v1 = volts_tab[base + seg + 1];
			res.flat = 1'b0;
			if (v1 == v0) begin
				r = c0;
				res.flat = 1'b1;
			end else begin
				num = (c1 - c0) * (t - v0);
				den = v1 - v0;
				if (den < 0) begin
					den = -den;
					num = -num;
				end
				num = 2 * num + den;
				den = 2 * den;
				q = num / den;
				if ((num % den) != 0 && num < 0)
					q = q - 1;
				r = c0 + q;
			end
			if (r < 0)
				r = 0;
			if (r > CODE_FULL)
				r = CODE_FULL;
			res.code = r[CODE_BITS-1:0];
			return res;
		endfunction

		function void note_transaction(cmd_t cmd, logic [1:0] dac, logic [2:0] pt,
				logic [VOLT_BITS-1:0] v, logic [CODE_BITS-1:0] code);
			int unsigned idx;
			if (cmd == CMD_LOAD) begin
				if (dac < DAC_COUNT && pt < POINT_COUNT) begin
					idx = dac * POINT_COUNT + pt;
					volts_tab[idx] = v;
					code_tab[idx] = code;
				end
			end else begin
				awaited.push_back(interpolate(dac, v));
			end
		endfunction

		function void check_result(logic [CODE_BITS-1:0] code, logic flat);
			dac_result_t exp_res;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result: dac_code %0d flat_segment %0b", code, flat));
			end else begin
				exp_res = awaited.pop_front();
				if (code !== exp_res.code)
					report($sformatf("dac_code mismatch: expected %0d, got %0d",
						exp_res.code, code));
				if (flat !== exp_res.flat)
					report($sformatf("flat_segment mismatch: expected %0b, got %0b",
						exp_res.flat, flat));
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 command;
	logic [1:0]           dac_select;
	logic [2:0]           point_index;
	logic [VOLT_BITS-1:0] volts;
	logic [CODE_BITS-1:0] point_code;
	logic                 done;
	logic [CODE_BITS-1:0] dac_code;
	logic                 flat_segment;

	dac_code_scoreboard   sb;
	int                   cycles;
	int                   sent;
	bit                   no_idle;
	logic [VOLT_BITS-1:0] new_volts [POINT_COUNT];
	logic [CODE_BITS-1:0] new_codes [POINT_COUNT];

	piecewise_linear_dac_calibration #(
		.DAC_COUNT(DAC_COUNT),
		.POINT_COUNT(POINT_COUNT),
		.CODE_BITS(CODE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.dac_select(dac_select),
		.point_index(point_index),
		.volts(volts),
		.point_code(point_code),
		.done(done),
		.dac_code(dac_code),
		.flat_segment(flat_segment)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(dac_code, flat_segment);
			if (start && !busy)
				sb.note_transaction(cmd_t'(command), dac_select, point_index, volts, point_code);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic send_item(cmd_t c, logic [1:0] d, logic [2:0] p,
			logic [VOLT_BITS-1:0] v, logic [CODE_BITS-1:0] code);
		@(negedge clk);
		start <= 1'b1;
		command <= c;
		dac_select <= d;
		point_index <= p;
		volts <= v;
		point_code <= code;
		do
			@(posedge clk);
		while (busy);
		if (c == CMD_CONVERT || (d < DAC_COUNT && p < POINT_COUNT))
			sent++;
	endtask

	task automatic pause(int unsigned n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 40);
		return $urandom_range(50, 200);
	endfunction

	task automatic idle_gap();
		if (!no_idle)
			pause(gap_len());
	endtask

	task automatic drain();
		pause(1);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic load_dac(logic [1:0] d);
		for (int i = 0; i < POINT_COUNT; i++) begin
			send_item(CMD_LOAD, d, 3'(i), new_volts[i], new_codes[i]);
			idle_gap();
		end
	endtask

	task automatic convert(logic [1:0] d, logic [VOLT_BITS-1:0] v);
		send_item(CMD_CONVERT, d, 3'($urandom), v, CODE_BITS'($urandom));
		idle_gap();
	endtask

	task automatic ignored_load();
		if ($urandom_range(0, 1) == 0)
			send_item(CMD_LOAD, 2'd3, 3'($urandom), VOLT_BITS'($urandom), CODE_BITS'($urandom));
		else
			send_item(CMD_LOAD, 2'($urandom_range(0, 3)), 3'd7, VOLT_BITS'($urandom),
				CODE_BITS'($urandom));
		idle_gap();
	endtask

	task automatic build_table(int unsigned kind);
		logic [VOLT_BITS-1:0] tv;
		logic [CODE_BITS-1:0] tc;
		int unsigned          k;
		for (int i = 0; i < POINT_COUNT; i++) begin
			new_volts[i] = VOLT_BITS'($urandom_range(0, VOLT_MAX));
			new_codes[i] = CODE_BITS'($urandom);
		end
		if (kind < 8) begin
			for (int i = 0; i < POINT_COUNT - 1; i++) begin
				for (int j = 0; j < POINT_COUNT - 1 - i; j++) begin
					if (new_volts[j] > new_volts[j + 1]) begin
						tv = new_volts[j];
						new_volts[j] = new_volts[j + 1];
						new_volts[j + 1] = tv;
					end
					if (kind < 6 && new_codes[j] > new_codes[j + 1]) begin
						tc = new_codes[j];
						new_codes[j] = new_codes[j + 1];
						new_codes[j + 1] = tc;
					end
				end
			end
			if ($urandom_range(0, 3) == 0) begin
				k = $urandom_range(0, POINT_COUNT - 2);
				new_volts[k + 1] = new_volts[k];
			end
		end else if (kind == 9) begin
			for (int i = 0; i < POINT_COUNT; i++)
				new_volts[i] = VOLT_BITS'($urandom);
		end
	endtask

	function automatic logic [VOLT_BITS-1:0] pick_target(logic [1:0] d);
		int unsigned r;
		int          v;
		int unsigned dd;
		r = $urandom_range(0, 99);
		dd = (d >= DAC_COUNT) ? DAC_COUNT - 1 : d;
		if (r < 30) begin
			v = sb.volts_tab[dd * POINT_COUNT + $urandom_range(0, POINT_COUNT - 1)];
			v = v + $urandom_range(0, 6) - 3;
			if (v < 0)
				v = 0;
			if (v > 32767)
				v = 32767;
			return VOLT_BITS'(v);
		end
		if (r < 65)
			return VOLT_BITS'($urandom_range(0, VOLT_MAX));
		if (r < 85)
			return VOLT_BITS'($urandom);
		case ($urandom_range(0, 4))
			0: return '0;
			1: return VOLT_MAX;
			2: return VOLT_MAX - 15'd1;
			3: return VOLT_MAX + 15'd1;
			default: return '1;
		endcase
	endfunction

	initial begin
		logic [1:0] d;
		int unsigned kind;
		sb = new();
		cycles = 0;
		sent = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_LOAD;
		dac_select = '0;
		point_index = '0;
		volts = '0;
		point_code = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		new_volts = '{15'd0, 15'd4096, 15'd8192, 15'd8192, 15'd12288, 15'd16384, 15'd20480};
		new_codes = '{12'd0, 12'd800, 12'd1600, 12'd1700, 12'd2500, 12'd3300, 12'd4095};
		load_dac(2'd0);
		new_volts = '{15'd2000, 15'd2000, 15'd10000, 15'd6000, 15'd14000, 15'd18000, 15'd18000};
		new_codes = '{12'd4095, 12'd3000, 12'd2000, 12'd2500, 12'd100, 12'd4095, 12'd0};
		load_dac(2'd1);
		new_volts = '{15'd100, 15'd102, 15'd4000, 15'd4001, 15'd8000, 15'd10000, 15'd12000};
		new_codes = '{12'd0, 12'd4095, 12'd100, 12'd200, 12'd300, 12'd0, 12'd4095};
		load_dac(2'd2);
		send_item(CMD_LOAD, 2'd3, 3'd7, 15'h7FFF, 12'hFFF);
		send_item(CMD_LOAD, 2'd0, 3'd7, 15'h7FFF, 12'hFFF);
		convert(2'd0, 15'd0);
		convert(2'd0, 15'd8192);
		convert(2'd0, VOLT_MAX);
		convert(2'd0, 15'h7FFF);
		convert(2'd1, 15'd1000);
		convert(2'd1, 15'd30000);
		convert(2'd1, 15'd8000);
		convert(2'd1, 15'd12000);
		convert(2'd2, 15'd0);
		convert(2'd2, 15'd101);
		convert(2'd3, 15'h7FFF);
		drain();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 7) == 0);
			d = 2'($urandom_range(0, DAC_COUNT - 1));
			kind = $urandom_range(0, 11);
			if (kind < 10) begin
				build_table(kind);
				load_dac(d);
			end else begin
				repeat ($urandom_range(1, 2)) begin
					send_item(CMD_LOAD, d, 3'($urandom_range(0, POINT_COUNT - 1)),
						VOLT_BITS'($urandom_range(0, VOLT_MAX)), CODE_BITS'($urandom));
					idle_gap();
				end
			end
			repeat ($urandom_range(5, 15)) begin
				if ($urandom_range(0, 19) == 0)
					ignored_load();
				if ($urandom_range(0, 3) == 0)
					d = 2'($urandom_range(0, 3));
				convert(d, pick_target(d));
			end
			if ($urandom_range(0, 19) == 0)
				drain();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
